FILE: sv/ura_pkg.sv
package ura_pkg;

  // Fixed timing of the trigger pulse, in microseconds.
  localparam int unsigned TRIG_LOW_US  = 2;
  localparam int unsigned TRIG_HIGH_US = 10;

  // Echo time per centimetre and the saturation point of the distance count.
  localparam int unsigned US_PER_CM = 58;
  localparam int unsigned CM_SAT    = 2047;

  // Counter and accumulator widths.
  localparam int unsigned PRESC_W = 8;
  localparam int unsigned US_W    = 17;
  localparam int unsigned SUB_W   = 6;
  localparam int unsigned CM_W    = 11;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SUM_W   = 13;

  // Serial divider: one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = 4;

  // Register defaults after reset.
  localparam logic [PRESC_W-1:0] RST_CYCLES_PER_US = 8'd150;
  localparam logic [TIME_W-1:0]  RST_TIMEOUT_US    = 16'd30000;
  localparam logic [DIST_W-1:0]  RST_MIN_CM        = 10'd2;
  localparam logic [DIST_W-1:0]  RST_MAX_CM        = 10'd400;
  localparam logic [DIST_W-1:0]  RST_ACCEPT_MAX_CM = 10'd80;
  localparam logic [CNT_W-1:0]   RST_SAMPLES       = 3'd5;
  localparam logic [TIME_W-1:0]  RST_GAP_US        = 16'd60000;

  // Configuration register map.
  typedef enum logic [2:0] {
    REG_CYCLES_PER_US = 3'd0,
    REG_TIMEOUT_US    = 3'd1,
    REG_MIN_CM        = 3'd2,
    REG_MAX_CM        = 3'd3,
    REG_ACCEPT_MAX_CM = 3'd4,
    REG_SAMPLES       = 3'd5,
    REG_GAP_US        = 3'd6
  } cfg_reg_t;

  // Measurement phases, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TLOW  = 6'b000010,
    PH_THIGH = 6'b000100,
    PH_WRISE = 6'b001000,
    PH_MEAS  = 6'b010000,
    PH_GAP   = 6'b100000
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic step;
    logic cm_en;
    logic burst_clr;
    logic acc_add;
    logic sample_inc;
    logic div_start;
    logic res_load;
    logic trig;
    logic busy;
    logic done;
    logic none;
  } ura_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick;
    logic us_ge_low;
    logic us_ge_high;
    logic us_gt_timeout;
    logic us_ge_gap;
    logic cm_ok;
    logic last_sample;
    logic acc_zero;
    logic div_busy;
    logic div_done;
  } ura_stat_t;

endpackage

FILE: sv/ura_ctrl.sv
module ura_ctrl
  import ura_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_start,
  input  logic      in_echo,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ura_stat_t stat,
  output ura_cmd_t  cmd
);

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  // A new beat is taken once the result register is free and no division runs.
  assign in_tready = (!out_valid_r || out_tready) && !stat.div_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Phase sequencing for one sample tick.
  always_comb begin
    phase_nxt = phase_r;
    cmd       = '0;
    if (in_fire) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_start) begin
            cmd.burst_clr = 1'b1;
            cmd.clr       = 1'b1;
            phase_nxt     = PH_TLOW;
          end
        end
        PH_TLOW: begin
          cmd.step = 1'b1;
          if (stat.tick && stat.us_ge_low) begin
            cmd.clr   = 1'b1;
            phase_nxt = PH_THIGH;
          end
        end
        PH_THIGH: begin
          cmd.step = 1'b1;
          if (stat.tick && stat.us_ge_high) begin
            cmd.clr   = 1'b1;
            phase_nxt = PH_WRISE;
          end
        end
        PH_WRISE: begin
          if (in_echo) begin
            cmd.clr   = 1'b1;
            phase_nxt = PH_MEAS;
          end else begin
            cmd.step = 1'b1;
            if (stat.tick && stat.us_gt_timeout) begin
              cmd.clr   = 1'b1;
              phase_nxt = PH_GAP;
            end
          end
        end
        PH_MEAS: begin
          if (!in_echo) begin
            // Falling echo closes the reading.
            cmd.acc_add = stat.cm_ok;
            cmd.clr     = 1'b1;
            phase_nxt   = PH_GAP;
          end else begin
            cmd.step  = 1'b1;
            cmd.cm_en = 1'b1;
            if (stat.tick && stat.us_gt_timeout) begin
              cmd.clr   = 1'b1;
              phase_nxt = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          if (stat.us_ge_gap) begin
            cmd.sample_inc = 1'b1;
            cmd.clr        = 1'b1;
            if (stat.last_sample) begin
              cmd.done      = 1'b1;
              cmd.none      = stat.acc_zero;
              cmd.div_start = !stat.acc_zero;
              phase_nxt     = PH_IDLE;
            end else begin
              phase_nxt = PH_TLOW;
            end
          end else begin
            cmd.step = 1'b1;
          end
        end
        default: begin
          cmd.clr   = 1'b1;
          phase_nxt = PH_IDLE;
        end
      endcase
      cmd.res_load = 1'b1;
      cmd.trig     = (phase_nxt == PH_THIGH);
      cmd.busy     = (phase_nxt != PH_IDLE);
    end
  end

  // Result register valid: a division holds it back until the quotient lands.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire && !cmd.div_start) begin
      out_valid_nxt = 1'b1;
    end
    if (stat.div_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/ura_dp.sv
module ura_dp
  import ura_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_wdata,
  input  ura_cmd_t          cmd,
  output ura_stat_t         stat,
  output logic              res_trig,
  output logic              res_busy,
  output logic              res_done,
  output logic [DIST_W-1:0] res_avg,
  output logic              res_none
);

  // Configuration registers.
  logic [PRESC_W-1:0] cycles_per_us_r;
  logic [TIME_W-1:0]  timeout_us_r;
  logic [DIST_W-1:0]  min_cm_r;
  logic [DIST_W-1:0]  max_cm_r;
  logic [DIST_W-1:0]  accept_max_cm_r;
  logic [CNT_W-1:0]   samples_r;
  logic [TIME_W-1:0]  gap_us_r;

  // Phase counters.
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic [US_W-1:0]    us_r, us_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [CM_W-1:0]    cm_r, cm_nxt;

  // Burst accumulation.
  logic [CNT_W-1:0] sample_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] acc_r;

  // Serial divider.
  logic [SUM_W-1:0]     div_q_r;
  logic [CNT_W-1:0]     div_rem_r;
  logic [CNT_W-1:0]     div_d_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       div_trial;
  logic                 div_ge;
  logic [CNT_W-1:0]     div_rem_step;
  logic [SUM_W-1:0]     div_q_step;

  // Result payload.
  logic              res_trig_r;
  logic              res_busy_r;
  logic              res_done_r;
  logic [DIST_W-1:0] res_avg_r;
  logic              res_none_r;

  logic [PRESC_W-1:0] presc_lim;
  logic [US_W-1:0]    us_inc;
  logic [SUB_W-1:0]   sub_inc;
  logic [CNT_W-1:0]   sample_inc;
  logic [CNT_W-1:0]   samples_eff;

  // Microsecond prescaler and status compares.
  assign presc_lim   = (cycles_per_us_r == '0) ? PRESC_W'(1) : cycles_per_us_r;
  assign us_inc      = us_r + US_W'(1);
  assign sub_inc     = sub_r + SUB_W'(1);
  assign sample_inc  = sample_r + CNT_W'(1);
  assign samples_eff = (samples_r == '0) ? CNT_W'(1) : samples_r;

  assign stat.tick          = ({1'b0, presc_r} + (PRESC_W+1)'(1)) >= {1'b0, presc_lim};
  assign stat.us_ge_low     = us_inc >= US_W'(TRIG_LOW_US);
  assign stat.us_ge_high    = us_inc >= US_W'(TRIG_HIGH_US);
  assign stat.us_gt_timeout = us_inc > {1'b0, timeout_us_r};
  assign stat.us_ge_gap     = us_r >= {1'b0, gap_us_r};
  assign stat.cm_ok         = (cm_r >= {1'b0, min_cm_r}) && (cm_r <= {1'b0, max_cm_r}) &&
                              (cm_r <= {1'b0, accept_max_cm_r});
  assign stat.last_sample   = sample_inc >= samples_eff;
  assign stat.acc_zero      = (acc_r == '0);
  assign stat.div_busy      = (div_cnt_r != '0);
  assign stat.div_done      = (div_cnt_r == DIV_CNT_W'(1));

  // Counter updates; entering a phase clears them all.
  always_comb begin
    presc_nxt = presc_r;
    us_nxt    = us_r;
    sub_nxt   = sub_r;
    cm_nxt    = cm_r;
    if (cmd.clr) begin
      presc_nxt = '0;
      us_nxt    = '0;
      sub_nxt   = '0;
      cm_nxt    = '0;
    end else if (cmd.step) begin
      if (stat.tick) begin
        presc_nxt = '0;
        us_nxt    = us_inc;
        if (cmd.cm_en) begin
          if (sub_inc >= SUB_W'(US_PER_CM)) begin
            sub_nxt = '0;
            if (cm_r < CM_W'(CM_SAT)) begin
              cm_nxt = cm_r + CM_W'(1);
            end
          end else begin
            sub_nxt = sub_inc;
          end
        end
      end else begin
        presc_nxt = presc_r + PRESC_W'(1);
      end
    end
  end

  // One restoring division step per cycle.
  assign div_trial    = {div_rem_r, div_q_r[SUM_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_d_r};
  assign div_rem_step = div_ge ? CNT_W'(div_trial - {1'b0, div_d_r}) : div_trial[CNT_W-1:0];
  assign div_q_step   = {div_q_r[SUM_W-2:0], div_ge};

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_per_us_r <= RST_CYCLES_PER_US;
      timeout_us_r    <= RST_TIMEOUT_US;
      min_cm_r        <= RST_MIN_CM;
      max_cm_r        <= RST_MAX_CM;
      accept_max_cm_r <= RST_ACCEPT_MAX_CM;
      samples_r       <= RST_SAMPLES;
      gap_us_r        <= RST_GAP_US;
      presc_r         <= '0;
      us_r            <= '0;
      sub_r           <= '0;
      cm_r            <= '0;
      sample_r        <= '0;
      sum_r           <= '0;
      acc_r           <= '0;
      div_cnt_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CYCLES_PER_US: cycles_per_us_r <= cfg_wdata[PRESC_W-1:0];
          REG_TIMEOUT_US:    timeout_us_r    <= cfg_wdata;
          REG_MIN_CM:        min_cm_r        <= cfg_wdata[DIST_W-1:0];
          REG_MAX_CM:        max_cm_r        <= cfg_wdata[DIST_W-1:0];
          REG_ACCEPT_MAX_CM: accept_max_cm_r <= cfg_wdata[DIST_W-1:0];
          REG_SAMPLES:       samples_r       <= cfg_wdata[CNT_W-1:0];
          REG_GAP_US:        gap_us_r        <= cfg_wdata;
          default: ;
        endcase
      end
      presc_r <= presc_nxt;
      us_r    <= us_nxt;
      sub_r   <= sub_nxt;
      cm_r    <= cm_nxt;
      if (cmd.burst_clr) begin
        sample_r <= '0;
        sum_r    <= '0;
        acc_r    <= '0;
      end else begin
        if (cmd.acc_add) begin
          sum_r <= sum_r + SUM_W'(cm_r);
          acc_r <= acc_r + CNT_W'(1);
        end
        if (cmd.sample_inc) begin
          sample_r <= sample_inc;
        end
      end
      if (cmd.div_start) begin
        div_cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (stat.div_busy) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // Divider operands and result payload.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q_r   <= sum_r;
      div_rem_r <= '0;
      div_d_r   <= acc_r;
    end else if (stat.div_busy) begin
      div_q_r   <= div_q_step;
      div_rem_r <= div_rem_step;
    end
    if (cmd.res_load) begin
      res_trig_r <= cmd.trig;
      res_busy_r <= cmd.busy;
      res_done_r <= cmd.done;
      res_none_r <= cmd.none;
      res_avg_r  <= '0;
    end else if (stat.div_done) begin
      res_avg_r <= div_q_step[DIST_W-1:0];
    end
  end

  assign res_trig = res_trig_r;
  assign res_busy = res_busy_r;
  assign res_done = res_done_r;
  assign res_avg  = res_avg_r;
  assign res_none = res_none_r;

endmodule

FILE: sv/ultrasonic_range_averager.sv
// Channel  Direction  Beat contents
// in_      input      tdata: start_req, echo (one beat per sample tick)
// out_     output     tdata: trig, busy_res, avg_cm; tlast: done_res; tuser: none_valid
// cfg_     input      register index and write data
//
// Each input beat yields one output beat, so the block runs one beat per
// clock while the output side keeps up and no division runs.
// The burst that ends with accepted readings then runs the serial
// divider (one quotient bit per cycle); in_tready is low while it runs.
// A full output register holds off in_tready until its beat is taken.
// Reset is synchronous on rst_n; control and configuration registers return to their default values.
module ultrasonic_range_averager
  import ura_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: [0] start_req, [1] echo, rest zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream: [0] trig, [1] busy_res, [11:2] avg_cm, rest zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // Result flag: [0] none_valid.
  output logic        out_tuser,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ura_cmd_t          cmd;
  ura_stat_t         stat;
  logic              res_trig;
  logic              res_busy;
  logic              res_done;
  logic [DIST_W-1:0] res_avg;
  logic              res_none;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  ura_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_start   (in_tdata[0]),
    .in_echo    (in_tdata[1]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ura_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .res_trig  (res_trig),
    .res_busy  (res_busy),
    .res_done  (res_done),
    .res_avg   (res_avg),
    .res_none  (res_none)
  );

  // Pack the result beat.
  assign out_tdata = {4'b0000, res_avg, res_busy, res_trig};
  assign out_tlast = res_done;
  assign out_tuser = res_none;

endmodule

FILE: sv/ura_checker.sv
module ura_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // The burst result comes with the block back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[1] && !out_tdata[0])
    else $error("burst result shows busy or trigger");

  // The none-valid flag only comes with a burst result.
  a_none_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("none_valid without done");

  // With no accepted reading the average is zero.
  a_none_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[11:2] == 10'd0)
    else $error("average given with none_valid");

  // Between results the average field stays zero.
  a_avg_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[11:2] == 10'd0)
    else $error("average outside a burst result");

  // The trigger pin is only driven high during a burst.
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("trigger high while idle");

endmodule

bind ultrasonic_range_averager ura_checker u_ura_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
